/* sv/psmf_pkg.sv */
// Package for the paged sparse memory: address geometry, action and size codes.
// Used by every module of the block; depends on nothing.
package psmf_pkg;

  localparam int ADDR_BITS = 20;
  localparam int PAGE_BITS = 12;
  localparam int PNUM_BITS = ADDR_BITS - PAGE_BITS;
  localparam int PAGE_COUNT = 1 << PNUM_BITS;

  localparam logic [15:0] LATENCY_RESET = 16'd10;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic REG_LATENCY = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CLEAR  = 4'b0010,
    S_ACCESS = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

endpackage

/* sv/paged_sparse_memory_with_faults.sv */
// Top level of the paged sparse memory with fault reporting.
// Depends on psmf_pkg, psmf_page_table and psmf_byte_mem.
//
// Usage: requests arrive on the in_valid/in_ready channel (action, access_size,
// address, write_data); each produces exactly one result on the out_valid/
// out_ready channel (read_data, success, fault, latency_cycles). in_ready is
// high only while the sequencer is idle. The latency register is
// written over the APB port at byte addresses 0 to 3 and is copied into
// latency_cycles for every read or write.
// Timing: one shared byte port serves all accesses, one byte per cycle. A
// read or write walks its n bytes (1, 2 or 4) in the access state; a read
// then waits in the final state for its last byte; a fault ends the byte
// walk early. A query, or adding a page that already exists, goes straight
// to the final state. Adding a new page zeroes it one byte per cycle, all
// 2^PAGE_BITS bytes (4096 with 4 KiB pages).
// Reset marks all pages absent and sets the latency register to LATENCY_RESET; store
// contents are not cleared. A result waits in the output register while the
// receiver stalls, and the next request can be taken meanwhile; it then holds
// in the final state until the output register is free.
module paged_sparse_memory_with_faults (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [1:0]                    access_size,
  input  logic [psmf_pkg::ADDR_BITS-1:0] address,
  input  logic [31:0]                   write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   read_data,
  output logic                          success,
  output logic                          fault,
  output logic [15:0]                   latency_cycles,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import psmf_pkg::*;

  state_t state;
  logic [15:0] lat_reg;

  logic [ADDR_BITS-1:0] addr_cur;
  logic [PAGE_BITS-1:0] clr_off;
  logic [1:0]  k;
  logic [1:0]  last;
  logic [31:0] wdata_r;
  logic [31:0] acc;
  logic        is_access;
  logic        is_write;
  logic        ok;
  logic        flt;
  logic        rd_pend;
  logic [1:0]  rd_lane;

  logic                 present;
  logic [PNUM_BITS-1:0] look_page;
  logic                 set_en;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic                 in_xfer;
  logic                 out_free;
  logic                 result_load;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LATENCY) ? {16'd0, lat_reg} : 32'd0;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign result_load = (state == S_DONE) && !rd_pend && out_free;

  // In idle the table answers for the incoming address, otherwise for the
  // address being walked or cleared.
  assign look_page = (state == S_IDLE) ? address[ADDR_BITS-1:PAGE_BITS]
                                       : addr_cur[ADDR_BITS-1:PAGE_BITS];
  assign set_en = (state == S_CLEAR) && (clr_off == {PAGE_BITS{1'b1}});

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_cur;
    mem_wdata = wdata_r[8*k +: 8];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = {addr_cur[ADDR_BITS-1:PAGE_BITS], clr_off};
        mem_wdata = 8'd0;
      end
      S_ACCESS: begin
        mem_we = present && is_write;
        mem_re = present && !is_write;
      end
      default: begin
      end
    endcase
  end

  psmf_page_table u_page_table (
    .clk       (clk),
    .rst       (rst),
    .set_en    (set_en),
    .set_page  (addr_cur[ADDR_BITS-1:PAGE_BITS]),
    .look_page (look_page),
    .present   (present)
  );

  psmf_byte_mem u_byte_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      lat_reg   <= LATENCY_RESET;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_LATENCY)) begin
        lat_reg <= pwdata[15:0];
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Read data arrives in the cycle after the byte is addressed.
      rd_pend <= (state == S_ACCESS) && present && !is_write;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if ((action == ACT_ADD) && !present) begin
              state <= S_CLEAR;
            end else if ((action == ACT_ADD) || (action == ACT_QUERY)) begin
              state <= S_DONE;
            end else begin
              state <= S_ACCESS;
            end
          end
        end
        S_CLEAR: begin
          if (set_en) begin
            state <= S_DONE;
          end
        end
        S_ACCESS: begin
          if (!present || (k == last)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      acc[8*rd_lane +: 8] <= mem_rdata;
    end
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          addr_cur  <= address;
          wdata_r   <= write_data;
          clr_off   <= '0;
          k         <= 2'd0;
          acc       <= 32'd0;
          flt       <= 1'b0;
          is_access <= (action == ACT_READ) || (action == ACT_WRITE);
          is_write  <= (action == ACT_WRITE);
          ok        <= (action == ACT_ADD) ? !present : present;
          if (access_size == SZ_BYTE) begin
            last <= 2'd0;
          end else if (access_size == SZ_HALF) begin
            last <= 2'd1;
          end else begin
            last <= 2'd3;
          end
        end
      end
      S_CLEAR: begin
        clr_off <= clr_off + 1'b1;
      end
      S_ACCESS: begin
        if (!present) begin
          flt <= 1'b1;
        end else begin
          rd_lane  <= k;
          k        <= k + 2'd1;
          addr_cur <= addr_cur + 1'b1;
        end
      end
      S_DONE: begin
        if (result_load) begin
          read_data      <= (is_access && !is_write && !flt) ? acc : 32'd0;
          success        <= is_access ? !flt : ok;
          fault          <= is_access && flt;
          latency_cycles <= is_access ? lat_reg : 16'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/psmf_page_table.sv */
// Page presence table: one flag per page, cleared by reset.
// Depends on psmf_pkg for the page geometry.
module psmf_page_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          set_en,
  input  logic [psmf_pkg::PNUM_BITS-1:0] set_page,
  input  logic [psmf_pkg::PNUM_BITS-1:0] look_page,
  output logic                          present
);
  import psmf_pkg::*;

  logic [PAGE_COUNT-1:0] flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (set_en) begin
      flags[set_page] <= 1'b1;
    end
  end

  assign present = flags[look_page];

endmodule

/* sv/psmf_byte_mem.sv */
// Byte-wide store covering the whole address space, one access per cycle.
// Depends on psmf_pkg for the address width; read data is registered.
module psmf_byte_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [psmf_pkg::ADDR_BITS-1:0] addr,
  input  logic [7:0]                    wdata,
  output logic [7:0]                    rdata
);
  import psmf_pkg::*;

  logic [7:0] mem [1 << ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for paged_sparse_memory_with_faults.
// It predicts each result from its own page map and byte image, then checks every output transfer.
// Depends on psmf_pkg and the RTL of the block.
module tb;
  import psmf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_NEW_PAGES = 20;
  localparam logic [2:0] LATENCY_ADDR = {REG_LATENCY, 2'b00};
  // Size code three behaves as a word.
  localparam logic [1:0] SZ_SPARE = 2'd3;

  typedef struct {
    logic [1:0]           action;
    logic [1:0]           size;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          wdata;
  } mem_request_t;

  typedef struct {
    logic [31:0] rdata;
    logic        ok;
    logic        flt;
    logic [15:0] lat;
  } mem_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           action = ACT_QUERY;
  logic [1:0]           access_size = SZ_BYTE;
  logic [ADDR_BITS-1:0] address = '0;
  logic [31:0]          write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          read_data;
  logic                 success;
  logic                 fault;
  logic [15:0]          latency_cycles;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  paged_sparse_memory_with_faults DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .access_size(access_size),
    .address(address),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .success(success),
    .fault(fault),
    .latency_cycles(latency_cycles),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Predicted state of the memory.
  bit          page_map [PAGE_COUNT];
  logic [7:0]  byte_image [0:(1 << ADDR_BITS) - 1];
  logic [15:0] lat_expected = LATENCY_RESET;

  mem_request_t request_queue [$];
  mem_result_t  pending_results [$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  // Stimulus-side view of which pages will be present, used to aim accesses.
  bit                   planned_present [PAGE_COUNT];
  logic [PNUM_BITS-1:0] added_pages [$];
  logic [PNUM_BITS-1:0] page_pool [$];
  logic [ADDR_BITS-1:0] recent_writes [$];
  int                   new_pages = 0;

  function automatic mem_result_t predict_memory_access(mem_request_t r);
    mem_result_t res;
    logic [ADDR_BITS-1:0] a;
    logic [PNUM_BITS-1:0] pg;
    int nbytes;
    res.rdata = '0;
    res.ok = 1'b0;
    res.flt = 1'b0;
    res.lat = '0;
    pg = r.addr[ADDR_BITS-1:PAGE_BITS];
    if (r.action == ACT_ADD) begin
      if (!page_map[pg]) begin
        page_map[pg] = 1'b1;
        for (int i = 0; i < (1 << PAGE_BITS); i++) byte_image[{pg, PAGE_BITS'(i)}] = 8'h00;
        res.ok = 1'b1;
      end
    end else if (r.action == ACT_QUERY) begin
      res.ok = page_map[pg];
    end else begin
      nbytes = (r.size == SZ_BYTE) ? 1 : (r.size == SZ_HALF) ? 2 : 4;
      res.lat = lat_expected;
      for (int k = 0; k < nbytes; k++) begin
        // The address wraps naturally at the width of the space.
        a = r.addr + ADDR_BITS'(k);
        if (!page_map[a[ADDR_BITS-1:PAGE_BITS]]) begin
          res.flt = 1'b1;
          break;
        end
        if (r.action == ACT_WRITE) byte_image[a] = r.wdata[8*k +: 8];
        else res.rdata[8*k +: 8] = byte_image[a];
      end
      res.ok = !res.flt;
      if (res.flt) res.rdata = '0;
    end
    return res;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    mem_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req = request_queue.pop_front();
          in_valid <= 1'b1;
          action <= req.action;
          access_size <= req.size;
          address <= req.addr;
          write_data <= req.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks output transfers, then predicts accepted requests.
  always @(posedge clk) begin
    mem_request_t req;
    mem_result_t exp_res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: read_data %h success %b fault %b latency_cycles %0d",
                 read_data, success, fault, latency_cycles);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (read_data !== exp_res.rdata) begin
            $error("read_data: expected %h, actual %h", exp_res.rdata, read_data);
            error_count++;
          end
          if (success !== exp_res.ok) begin
            $error("success: expected %b, actual %b", exp_res.ok, success);
            error_count++;
          end
          if (fault !== exp_res.flt) begin
            $error("fault: expected %b, actual %b", exp_res.flt, fault);
            error_count++;
          end
          if (latency_cycles !== exp_res.lat) begin
            $error("latency_cycles: expected %0d, actual %0d", exp_res.lat, latency_cycles);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        req.action = action;
        req.size = access_size;
        req.addr = address;
        req.wdata = write_data;
        pending_results.push_back(predict_memory_access(req));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LATENCY_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(output logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LATENCY_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    value = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_latency_reg();
    logic [31:0] rd;
    apb_read(rd);
    if (rd[15:0] !== lat_expected) begin
      $error("latency register: expected %0d, actual %0d", lat_expected, rd[15:0]);
      error_count++;
    end
  endtask

  task automatic set_access_latency(input logic [15:0] value);
    apb_write({16'h0000, value});
    lat_expected = value;
    verify_latency_reg();
  endtask

  task automatic push_request(input logic [1:0] act, input logic [1:0] sz,
                              input logic [ADDR_BITS-1:0] a, input logic [31:0] wd);
    mem_request_t r;
    r.action = act;
    r.size = sz;
    r.addr = a;
    r.wdata = wd;
    request_queue.push_back(r);
    if (act == ACT_ADD && !planned_present[a[ADDR_BITS-1:PAGE_BITS]]) begin
      planned_present[a[ADDR_BITS-1:PAGE_BITS]] = 1'b1;
      added_pages.push_back(a[ADDR_BITS-1:PAGE_BITS]);
    end
    if (act == ACT_WRITE) begin
      recent_writes.push_back(a);
      if (recent_writes.size() > 16) void'(recent_writes.pop_front());
    end
  endtask

  // Sampled away from the rising edge so that every driver update has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random_requests(input int count);
    int pick;
    logic [1:0] act;
    logic [1:0] sz;
    logic [PNUM_BITS-1:0] pg;
    logic [PAGE_BITS-1:0] off;
    logic [ADDR_BITS-1:0] a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      sz = 2'($urandom_range(3));
      // Offsets near the end of a page make accesses cross page boundaries; some sit at its start.
      case ($urandom_range(2))
        0: off = PAGE_BITS'($urandom);
        1: off = PAGE_BITS'($urandom_range(3));
        default: off = PAGE_BITS'($urandom_range((1 << PAGE_BITS) - 1, (1 << PAGE_BITS) - 4));
      endcase
      if (pick < 6) begin
        act = ACT_ADD;
        pg = page_pool[$urandom_range(page_pool.size() - 1)];
        if (!planned_present[pg]) begin
          if (new_pages < MAX_NEW_PAGES) new_pages++;
          else pg = added_pages[$urandom_range(added_pages.size() - 1)];
        end
        a = {pg, off};
      end else if (pick < 14) begin
        act = ACT_QUERY;
        a = ADDR_BITS'($urandom);
      end else begin
        act = (pick < 57) ? ACT_READ : ACT_WRITE;
        if (act == ACT_READ && recent_writes.size() > 0 && $urandom_range(99) < 40) begin
          a = ADDR_BITS'(recent_writes[$urandom_range(recent_writes.size() - 1)]
                         + $urandom_range(4) - 2);
        end else begin
          if ($urandom_range(99) < 80) pg = added_pages[$urandom_range(added_pages.size() - 1)];
          else pg = page_pool[$urandom_range(page_pool.size() - 1)];
          a = {pg, off};
        end
      end
      push_request(act, sz, a, $urandom);
    end
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall,
                           input logic [15:0] latency, input int count);
    set_access_latency(latency);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    @(negedge clk);
    queue_random_requests(count);
    wait_drained();
  endtask

  initial begin
    page_pool = '{8'h00, 8'h01, 8'hFF, 8'hFE, 8'h55, 8'hAA, 8'h7F, 8'h80};
    repeat (16) page_pool.push_back(PNUM_BITS'($urandom));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    verify_latency_reg();

    @(negedge clk);
    // Accesses to a memory with no pages must all fault.
    push_request(ACT_QUERY, SZ_BYTE,  20'h00000, 32'h0);
    push_request(ACT_READ,  SZ_WORD,  20'h00000, 32'h0);
    push_request(ACT_WRITE, SZ_WORD,  20'h00000, 32'hFFFFFFFF);
    push_request(ACT_ADD,   SZ_BYTE,  20'h00ABC, 32'h0);
    push_request(ACT_ADD,   SZ_BYTE,  20'h00000, 32'h0);
    push_request(ACT_QUERY, SZ_BYTE,  20'h00FFF, 32'h0);
    // A write running into an absent page keeps only its leading bytes.
    push_request(ACT_WRITE, SZ_WORD,  20'h00FFE, 32'hDEADBEEF);
    push_request(ACT_READ,  SZ_HALF,  20'h00FFE, 32'h0);
    push_request(ACT_READ,  SZ_WORD,  20'h00FFD, 32'h0);
    push_request(ACT_ADD,   SZ_BYTE,  20'hFF000, 32'h0);
    // Accesses at the top of the space wrap to address zero.
    push_request(ACT_WRITE, SZ_WORD,  20'hFFFFE, 32'hFFFFFFFF);
    push_request(ACT_READ,  SZ_SPARE, 20'hFFFFF, 32'h0);
    push_request(ACT_WRITE, SZ_HALF,  20'h00010, 32'h00000000);
    push_request(ACT_WRITE, SZ_BYTE,  20'h7F123, 32'h000000A5);
    push_request(ACT_READ,  SZ_BYTE,  20'hFFFFF, 32'h0);
    push_request(ACT_ADD,   SZ_BYTE,  20'h01FFF, 32'h0);
    push_request(ACT_READ,  SZ_WORD,  20'h00FFE, 32'h0);
    push_request(ACT_WRITE, SZ_SPARE, 20'h00FFF, 32'h12345678);
    push_request(ACT_READ,  SZ_WORD,  20'h00FFF, 32'h0);
    push_request(ACT_QUERY, SZ_BYTE,  20'hFFFFF, 32'h0);
    push_request(ACT_QUERY, SZ_BYTE,  20'h80000, 32'h0);
    push_request(ACT_WRITE, SZ_HALF,  20'hFFFFF, 32'h5A5AA5A5);
    push_request(ACT_READ,  SZ_HALF,  20'hFFFFF, 32'h0);
    wait_drained();

    run_phase(0, 0, 16'h0000, 120);
    run_phase(53, 0, 16'hFFFF, 120);
    run_phase(0, 53, 16'($urandom), 120);
    run_phase(12, 12, 16'd1, 120);

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
